[rtl/core/vald_pkg.sv]
`default_nettype none
package vald_pkg;
  localparam int MaxChannels = 8;
  localparam int MaxBlock = 1024;
  localparam logic signed [15:0] DbFloor = -16'sd23040;
  localparam logic signed [15:0] DbCeil = 16'sd6144;
  localparam logic [18:0] DbPerOctave = 19'd394566;
  localparam logic [10:0] SwitchMax = 11'd2047;

  localparam logic [2:0] RegChannelCount = 3'd0;
  localparam logic [2:0] RegBlockLength = 3'd1;
  localparam logic [2:0] RegDecayCoef = 3'd2;
  localparam logic [2:0] RegFullScale = 3'd3;
  localparam logic [2:0] RegAttackThresh = 3'd4;
  localparam logic [2:0] RegReleaseThresh = 3'd5;
  localparam logic [2:0] RegAttackHold = 3'd6;
  localparam logic [2:0] RegReleaseHold = 3'd7;

  typedef struct packed {
    logic [3:0] channel_count;
    logic [10:0] block_length;
    logic [15:0] decay_coef;
    logic [15:0] full_scale;
    logic signed [15:0] attack_thresh;
    logic signed [15:0] release_thresh;
    logic [9:0] attack_hold;
    logic [9:0] release_hold;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture sample, update envelope
    logic norm_env;   // load log unit with envelope
    logic norm_fs;    // load log unit with full scale
    logic sq_step;    // one squaring step
    logic save_env;   // keep envelope log
    logic db_calc;    // form dB product
    logic db_acc;     // round, clamp, accumulate
    logic div_start;
    logic div_step;
    logic detect;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_floor;
    logic block_done;
    logic div_last;
  } sts_t;
endpackage
`default_nettype wire

[rtl/core/vald_ctrl.sv]
`default_nettype none
module vald_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic analyse,
  input  wire vald_pkg::sts_t sts,
  input  wire logic out_free,
  output vald_pkg::cmd_t cmd,
  output logic busy,
  output logic emit
);
  import vald_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHK   = 11'b00000000010,
    S_NENV  = 11'b00000000100,
    S_SQE   = 11'b00000001000,
    S_NFS   = 11'b00000010000,
    S_SQF   = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_ACC   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_DET   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    emit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && analyse) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.is_floor) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_NENV;
        end
      end
      S_NENV: begin
        cmd.norm_env = 1'b1;
        cnt_nxt = 4'd0;
        state_nxt = S_SQE;
      end
      S_SQE: begin
        cmd.sq_step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_NFS;
      end
      S_NFS: begin
        cmd.save_env = 1'b1;
        cmd.norm_fs = 1'b1;
        state_nxt = S_SQF;
      end
      S_SQF: begin
        cmd.sq_step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.db_calc = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.db_acc = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.block_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DET;
        end
      end
      S_DET: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.detect = 1'b1;
          emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/vald_dp.sv]
`default_nettype none
module vald_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire vald_pkg::cfg_t cfg,
  input  wire vald_pkg::cmd_t cmd,
  input  wire logic signed [15:0] sample,
  output vald_pkg::sts_t sts,
  output logic signed [15:0] mean_db,
  output logic voice_on
);
  import vald_pkg::*;

  logic [31:0] env_r;
  logic [15:0] fs;
  logic [16:0] mag;
  logic [31:0] mag_q;
  logic [47:0] dec_prod;
  logic [31:0] m_r;
  logic [4:0] n_r;
  logic [15:0] frac_r;
  logic [20:0] lenv_r;
  logic signed [22:0] l_val;
  logic signed [42:0] p_r;
  logic signed [42:0] p_q;
  logic signed [15:0] db_c;
  logic is_floor;
  logic signed [25:0] sum_r;
  logic [10:0] cnt_r;
  logic [10:0] bl;
  // divider
  logic [25:0] dq_r;
  logic [10:0] drem_r;
  logic [10:0] dden_r;
  logic dneg_r;
  logic [4:0] dstep_r;
  logic [11:0] dtrial;
  logic tent_r, stat_r;
  logic signed [15:0] mean_r;
  logic [10:0] sw_r;

  assign fs = (cfg.full_scale == 16'd0) ? 16'd1 : cfg.full_scale;
  assign mag = (sample < 0) ? 17'(-$signed({sample[15], sample})) : {1'b0, sample};
  assign mag_q = {mag[15:0], 16'd0};
  assign dec_prod = env_r * cfg.decay_coef;
  assign bl = (cfg.block_length == 11'd0) ? 11'd1 :
              (cfg.block_length > 11'(MaxBlock)) ? 11'(MaxBlock) : cfg.block_length;

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

  logic [4:0] nsrc;
  logic [31:0] xsrc;
  logic [63:0] sq;
  logic [32:0] sq_sh;
  assign xsrc = cmd.norm_env ? env_r : {16'd0, fs};
  assign nsrc = msb_pos(xsrc);
  assign sq = m_r * m_r;
  assign sq_sh = 33'(sq >> 31);
  assign l_val = $signed({2'b00, lenv_r}) - $signed(23'(16 * 65536))
               - $signed({2'b00, n_r, frac_r});

  // floor test on the envelope held since load
  assign is_floor = (({17'd0, env_r} * 49'd100000) < ({33'd0, fs} * 49'd196608));

  // arithmetic shift floors the quotient
  assign p_q = p_r >>> 24;
  assign db_c = (p_q < 43'(DbFloor)) ? DbFloor :
                (p_q > 43'(DbCeil)) ? DbCeil : 16'(p_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
      tent_r <= 1'b0;
      stat_r <= 1'b0;
      sw_r <= '0;
    end else begin
      if (cmd.load) begin
        env_r <= (mag_q > env_r) ? mag_q : dec_prod[47:16];
      end
      if (cmd.db_acc) begin
        sum_r <= sum_r + 26'(is_floor ? DbFloor : db_c);
        cnt_r <= cnt_r + 11'd1;
      end
      if (cmd.div_start) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.detect) begin
        logic [10:0] sw;
        logic tn;
        sw = (sw_r < SwitchMax) ? sw_r + 11'd1 : sw_r;
        tn = tent_r;
        if (!tent_r) begin
          if (mean_r > cfg.attack_thresh) begin tn = 1'b1; sw = '0; end
        end else if (mean_r < cfg.release_thresh) begin
          tn = 1'b0; sw = '0;
        end
        tent_r <= tn;
        sw_r <= sw;
        if (tn != stat_r) begin
          if (tn) begin
            if (sw > {1'b0, cfg.attack_hold}) stat_r <= 1'b1;
          end else if (sw > {1'b0, cfg.release_hold}) begin
            stat_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_env || cmd.norm_fs) begin
      n_r <= nsrc;
      m_r <= xsrc << (5'd31 - nsrc);
      frac_r <= '0;
    end else if (cmd.sq_step) begin
      if (sq_sh[32]) begin
        m_r <= sq_sh[32:1];
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        m_r <= sq_sh[31:0];
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
    if (cmd.save_env) lenv_r <= {n_r, frac_r};
    if (cmd.db_calc) p_r <= 43'(l_val * $signed({1'b0, DbPerOctave})) + 43'sd8388608;
    if (cmd.div_start) begin
      dneg_r <= sum_r[25];
      dq_r <= sum_r[25] ? 26'(-sum_r) : 26'(sum_r);
      dden_r <= cnt_r;
      drem_r <= '0;
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, dden_r}) begin
        drem_r <= 11'(dtrial - {1'b0, dden_r});
        dq_r <= {dq_r[24:0], 1'b1};
      end else begin
        drem_r <= dtrial[10:0];
        dq_r <= {dq_r[24:0], 1'b0};
      end
      dstep_r <= dstep_r + 5'd1;
    end
  end

  // block complete is tested after accumulate, so count already holds this sample
  assign sts.block_done = (cnt_r >= bl);
  assign sts.is_floor = is_floor;
  assign sts.div_last = (dstep_r == 5'd25);
  assign dtrial = {drem_r, dq_r[25]};

  always_ff @(posedge clk) begin
    if (cmd.div_step && sts.div_last) mean_r <= dneg_r ? -$signed(16'(
      (dtrial >= {1'b0, dden_r}) ? {dq_r[14:0], 1'b1} : {dq_r[14:0], 1'b0})) :
      $signed(16'((dtrial >= {1'b0, dden_r}) ? {dq_r[14:0], 1'b1} : {dq_r[14:0], 1'b0}));
  end

  assign mean_db = mean_r;
  assign voice_on = stat_r;
endmodule
`default_nettype wire

[rtl/core/voice_activity_level_detector.sv]
`default_nettype none
// channel  dir  payload
// in_      in   tdata[15:0] sample
// out_     out  tdata[15:0] mean_db, tuser[1:0] status_changed, voice_on
// cfg_     in   wr_en, index[2:0], data[15:0]
// skipped channels are taken without leaving idle; an analysed sample goes
// straight to accumulate at the floor and otherwise through the two 16 step
// log squaring loops; a block end adds 26 restoring divider steps and the emit;
// synchronous active low reset; output holds a register stage, input
// is refused while a sample is in work, including a block end that waits
// for the output register to free up
module voice_activity_level_detector (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [15:0] in_tdata,   // sample
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [15:0] out_tdata,       // mean_db
  output logic [1:0] out_tuser,        // status_changed, voice_on
  input  wire logic cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import vald_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, emit, in_fire;
  logic [2:0] phase_r;
  logic [3:0] cc;
  logic ov_r;
  logic [15:0] ob_mean_r;
  logic [1:0] ob_user_r;
  logic signed [15:0] mean_db;
  logic voice_on, stat_before_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= 4'd1;
      cfg_r.block_length <= 11'd48;
      cfg_r.decay_coef <= 16'd65193;
      cfg_r.full_scale <= 16'd32768;
      cfg_r.attack_thresh <= -16'sd7680;
      cfg_r.release_thresh <= -16'sd10240;
      cfg_r.attack_hold <= 10'd30;
      cfg_r.release_hold <= 10'd30;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegChannelCount: cfg_r.channel_count <= cfg_data[3:0];
        RegBlockLength: cfg_r.block_length <= cfg_data[10:0];
        RegDecayCoef: cfg_r.decay_coef <= cfg_data;
        RegFullScale: cfg_r.full_scale <= cfg_data;
        RegAttackThresh: cfg_r.attack_thresh <= cfg_data;
        RegReleaseThresh: cfg_r.release_thresh <= cfg_data;
        RegAttackHold: cfg_r.attack_hold <= cfg_data[9:0];
        RegReleaseHold: cfg_r.release_hold <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign cc = (cfg_r.channel_count == 4'd0) ? 4'd1 :
              (cfg_r.channel_count > 4'(MaxChannels)) ? 4'(MaxChannels) : cfg_r.channel_count;
  assign in_tready = ~busy;
  assign in_fire = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= '0;
    else if (in_fire) phase_r <= (({1'b0, phase_r} + 4'd1) >= cc) ? 3'd0 : phase_r + 3'd1;
  end

  vald_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .analyse(phase_r == 3'd0), .sts,
    .out_free(~ov_r | out_tready), .cmd, .busy, .emit
  );

  vald_dp u_dp (
    .clk, .rst_n, .cfg(cfg_r), .cmd, .sample(in_tdata), .sts,
    .mean_db, .voice_on
  );

  // status is updated at emit, so the beat is formed in the cycle after emit
  logic emit_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      emit_d_r <= 1'b0;
      stat_before_r <= 1'b0;
    end else begin
      emit_d_r <= emit;
      if (emit) stat_before_r <= voice_on;
      if (emit_d_r) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_d_r) begin
      ob_mean_r <= mean_db;
      ob_user_r <= {voice_on != stat_before_r, voice_on};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = ob_mean_r;
  assign out_tuser = ob_user_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken while busy");
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!ov_r || out_tready)) else $error("result slot overwritten");
  a_emit_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_tvalid == $past(ov_r && !out_tready) || !out_tvalid)
    else $error("emit sequence broken");
endmodule
`default_nettype wire
